[hdl/vs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the vector slerp pipeline.
package vs_pkg;

	localparam int FRAC_BITS    = 14;
	localparam int ONE          = 1 << FRAC_BITS;
	localparam int ANG_BITS     = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W     = 34;
	localparam int ROOT_W       = ANG_BITS + 1;
	localparam int SQ_STEPS     = ROOT_W;
	localparam int REM_W        = 2 * ROOT_W;
	localparam int NUM_W        = 52;
	localparam int QUO_W        = 18;
	localparam int DIV_STEPS    = QUO_W;
	localparam int PROD_W       = CORDIC_W + 16;
	localparam int WP_W         = CORDIC_W + 17;
	localparam int THR_W        = 15;
	localparam logic [THR_W-1:0] THRESH_RESET = 15'd16376;
	localparam logic [CORDIC_W-1:0] INV_GAIN  = 34'd652032874;

	typedef logic signed [15:0]          comp_t;
	typedef logic signed [16:0]          wcomp_t;
	typedef logic signed [CORDIC_W-1:0]  cw_t;

	// Per-item context that rides alongside the cell chains.
	typedef struct packed {
		comp_t [2:0]       s;
		wcomp_t [2:0]      e;
		logic [14:0]       t;
		comp_t [2:0]       lin_res;
		logic              linear;
		logic [ROOT_W-1:0] big_d;
		logic [ROOT_W-1:0] sin_th;
	} ctx_t;

	// CORDIC step angle in Q30: arctangent table for the first ten, then 2^-i.
	function automatic cw_t step_angle(input logic [4:0] idx);
		cw_t a;
		case (idx)
			5'd0: a = 34'sd843314857;
			5'd1: a = 34'sd497837829;
			5'd2: a = 34'sd263043837;
			5'd3: a = 34'sd133525159;
			5'd4: a = 34'sd67021687;
			5'd5: a = 34'sd33543516;
			5'd6: a = 34'sd16775851;
			5'd7: a = 34'sd8388437;
			5'd8: a = 34'sd4194283;
			5'd9: a = 34'sd2097149;
			default: a = cw_t'({{(CORDIC_W-1){1'b0}}, 1'b1} << (5'(ANG_BITS) - idx));
		endcase
		return a;
	endfunction

	function automatic comp_t sat16(input logic signed [20:0] v);
		comp_t r;
		if (v > 21'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -21'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

[hdl/vs_sqrt_cell.sv]
`timescale 1ns / 1ps
// One bit of a pipelined restoring integer square root.
module vs_sqrt_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [4:0]                 sh,
	input  logic [vs_pkg::REM_W-1:0]   rem_in,
	input  logic [vs_pkg::ROOT_W-1:0]  root_in,
	output logic [vs_pkg::REM_W-1:0]   rem_q,
	output logic [vs_pkg::ROOT_W-1:0]  root_q
);
	import vs_pkg::*;

	logic [REM_W-1:0] inc;
	logic             take;

	// (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
	always_comb begin
		inc  = ({{ROOT_W{1'b0}}, root_in} << ({1'b0, sh} + 6'd1))
			| ({{(REM_W-1){1'b0}}, 1'b1} << ({1'b0, sh} << 1));
		take = rem_in >= inc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? rem_in - inc : rem_in;
			root_q <= take ? root_in | ({{(ROOT_W-1){1'b0}}, 1'b1} << sh) : root_in;
		end
	end

endmodule

[hdl/vs_cordic_cell.sv]
`timescale 1ns / 1ps
// One CORDIC micro-rotation, vectoring or rotation mode.
module vs_cordic_cell (
	input  logic        clk,
	input  logic        en,
	input  logic        rotate,
	input  logic [4:0]  idx,
	input  vs_pkg::cw_t x_in,
	input  vs_pkg::cw_t y_in,
	input  vs_pkg::cw_t z_in,
	output vs_pkg::cw_t x_q,
	output vs_pkg::cw_t y_q,
	output vs_pkg::cw_t z_q
);
	import vs_pkg::*;

	cw_t  dx;
	cw_t  dy;
	cw_t  ang;
	logic ccw;

	always_comb begin
		dx  = y_in >>> idx;
		dy  = x_in >>> idx;
		ang = step_angle(idx);
		// rotation follows the residual angle, vectoring drives y toward zero
		ccw = rotate ? !z_in[CORDIC_W-1] : (y_in[CORDIC_W-1] || (y_in == '0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= ccw ? x_in - dx : x_in + dx;
			y_q <= ccw ? y_in + dy : y_in - dy;
			z_q <= ccw ? z_in - ang : z_in + ang;
		end
	end

endmodule

[hdl/vs_div_cell.sv]
`timescale 1ns / 1ps
// One quotient bit of a pipelined restoring divider.
module vs_div_cell (
	input  logic                      clk,
	input  logic                      en,
	input  logic [4:0]                sh,
	input  logic [vs_pkg::ROOT_W-1:0] den,
	input  logic [vs_pkg::NUM_W-1:0]  rem_in,
	input  logic [vs_pkg::QUO_W-1:0]  quo_in,
	output logic [vs_pkg::NUM_W-1:0]  rem_q,
	output logic [vs_pkg::QUO_W-1:0]  quo_q
);
	import vs_pkg::*;

	logic [NUM_W-1:0] dsh;
	logic             take;

	always_comb begin
		dsh  = {{(NUM_W-ROOT_W){1'b0}}, den} << sh;
		take = rem_in >= dsh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? rem_in - dsh : rem_in;
			quo_q <= take ? quo_in | ({{(QUO_W-1){1'b0}}, 1'b1} << sh) : quo_in;
		end
	end

endmodule

[hdl/vector_slerp_top.sv]
`timescale 1ns / 1ps
// Top level of the vector slerp pipeline: front end, cell chains and output register.
// Stages from input beat to output beat: 4 front stages, 31 square root cells,
// 30 vectoring CORDIC cells, 1 angle stage, 30 rotation CORDIC cells, 2 product
// stages, 18 divider cells, 1 output register. Throughput: one beat per cycle; the
// whole chain advances together and halts only while the output beat is not taken.
// Reset: arst_n clears all valid bits and loads thr_q with 16376.
module vector_slerp_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [vs_pkg::THR_W-1:0]   cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  vs_pkg::comp_t              start_x,
	input  vs_pkg::comp_t              start_y,
	input  vs_pkg::comp_t              start_z,
	input  vs_pkg::comp_t              end_x,
	input  vs_pkg::comp_t              end_y,
	input  vs_pkg::comp_t              end_z,
	input  logic [14:0]                blend,
	output logic                       out_valid,
	input  logic                       out_ready,
	output vs_pkg::comp_t              out_x,
	output vs_pkg::comp_t              out_y,
	output vs_pkg::comp_t              out_z,
	output logic                       linear_path
);
	import vs_pkg::*;

	// Global advance: every stage moves when the output register is free or drained.
	logic adv;
	logic out_valid_q;
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;

	logic [THR_W-1:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	comp_t s_in [3];
	comp_t e_in [3];
	assign s_in[0] = start_x;
	assign s_in[1] = start_y;
	assign s_in[2] = start_z;
	assign e_in[0] = end_x;
	assign e_in[1] = end_y;
	assign e_in[2] = end_z;

	// ---------------- front stage 1: capture, clamp t, component products
	logic                v_s1;
	comp_t               s_s1 [3];
	comp_t               e_s1 [3];
	logic [14:0]         t_s1;
	logic signed [31:0]  p_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= (blend > 15'(ONE)) ? 15'(ONE) : blend;
			for (int k = 0; k < 3; k++) begin
				s_s1[k] <= s_in[k];
				e_s1[k] <= e_in[k];
				p_s1[k] <= s_in[k] * e_in[k];
			end
		end
	end

	// ---------------- front stage 2: sum, fold the sign, round the dot to Q14
	logic               v_s2;
	comp_t              s_s2 [3];
	wcomp_t             e_s2 [3];
	logic [14:0]        t_s2;
	logic [19:0]        d_s2;
	logic signed [33:0] dot;
	logic [33:0]        dot_mag;
	logic [33:0]        dot_rnd;

	always_comb begin
		dot = {{2{p_s1[0][31]}}, p_s1[0]} + {{2{p_s1[1][31]}}, p_s1[1]}
			+ {{2{p_s1[2][31]}}, p_s1[2]};
		dot_mag = dot[33] ? 34'(-dot) : 34'(dot);
		dot_rnd = dot_mag + 34'(ONE / 2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2 <= t_s1;
			d_s2 <= dot_rnd[33:FRAC_BITS];
			for (int k = 0; k < 3; k++) begin
				s_s2[k] <= s_s1[k];
				// negated end vector keeps -(-32768) at full width
				e_s2[k] <= dot[33] ? -{e_s1[k][15], e_s1[k]} : {e_s1[k][15], e_s1[k]};
			end
		end
	end

	// ---------------- front stage 3: threshold, clamp, D^2 and lerp products
	logic               v_s3;
	comp_t              s_s3 [3];
	logic [14:0]        t_s3;
	wcomp_t             e_s3 [3];
	logic               lin_s3;
	logic [28:0]        dc2_s3;
	logic [ROOT_W-1:0]  big_d_s3;
	logic signed [33:0] lp_s3 [3];
	logic [14:0]        dc;
	logic signed [15:0] t_sg;
	logic signed [17:0] diff [3];

	always_comb begin
		dc   = (d_s2 > 20'(ONE)) ? 15'(ONE) : d_s2[14:0];
		t_sg = {1'b0, t_s2};
		for (int k = 0; k < 3; k++) begin
			diff[k] = {e_s2[k][16], e_s2[k]} - {{2{s_s2[k][15]}}, s_s2[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s3     <= t_s2;
			lin_s3   <= d_s2 > {5'b0, thr_q};
			dc2_s3   <= 29'(dc) * 29'(dc);
			big_d_s3 <= {dc, 16'b0};
			for (int k = 0; k < 3; k++) begin
				s_s3[k]  <= s_s2[k];
				e_s3[k]  <= e_s2[k];
				lp_s3[k] <= diff[k] * t_sg;
			end
		end
	end

	// ---------------- front stage 4: finish the lerp, form the square root radicand
	logic        v_s4;
	ctx_t        ctx_s4;
	logic [28:0] rad_s4;
	logic [33:0] lp_mag [3];
	logic [33:0] lp_rnd [3];
	logic signed [20:0] lin_sum [3];
	comp_t       lin_res [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lp_mag[k] = lp_s3[k][33] ? 34'(-lp_s3[k]) : 34'(lp_s3[k]);
			lp_rnd[k] = lp_mag[k] + 34'(ONE / 2);
			// round half away from zero, then add start
			lin_sum[k] = {{5{s_s3[k][15]}}, s_s3[k]}
				+ (lp_s3[k][33] ? -{1'b0, lp_rnd[k][33:FRAC_BITS]}
					: {1'b0, lp_rnd[k][33:FRAC_BITS]});
			lin_res[k] = sat16(lin_sum[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s4         <= 29'(1 << 28) - dc2_s3;
			ctx_s4.t       <= t_s3;
			ctx_s4.linear  <= lin_s3;
			ctx_s4.big_d   <= big_d_s3;
			ctx_s4.sin_th  <= '0;
			for (int k = 0; k < 3; k++) begin
				ctx_s4.s[k]       <= s_s3[k];
				ctx_s4.e[k]       <= e_s3[k];
				ctx_s4.lin_res[k] <= lin_res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ---------------- square root chain: sin(theta) = isqrt(2^60 - D^2)
	logic [REM_W-1:0]  sq_rem  [SQ_STEPS+1];
	logic [ROOT_W-1:0] sq_root [SQ_STEPS+1];
	ctx_t              sq_ctx  [SQ_STEPS+1];
	logic              sq_vld  [SQ_STEPS+1];

	assign sq_rem[0]  = {1'b0, rad_s4, 32'b0};
	assign sq_root[0] = '0;
	assign sq_ctx[0]  = ctx_s4;
	assign sq_vld[0]  = v_s4;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		vs_sqrt_cell u_cell (
			.clk     (clk),
			.en      (adv),
			.sh      (5'(SQ_STEPS - 1 - i)),
			.rem_in  (sq_rem[i]),
			.root_in (sq_root[i]),
			.rem_q   (sq_rem[i+1]),
			.root_q  (sq_root[i+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[i+1] <= 1'b0;
			end else if (adv) begin
				sq_vld[i+1] <= sq_vld[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_ctx[i+1] <= sq_ctx[i];
			end
		end
	end

	// ---------------- vectoring CORDIC chain: theta = atan2(sin, D)
	cw_t  vc_x   [CORDIC_STEPS+1];
	cw_t  vc_y   [CORDIC_STEPS+1];
	cw_t  vc_z   [CORDIC_STEPS+1];
	ctx_t vc_ctx [CORDIC_STEPS+1];
	logic vc_vld [CORDIC_STEPS+1];

	// drop to the linear blend when the sine of theta is zero
	always_comb begin
		vc_ctx[0]        = sq_ctx[SQ_STEPS];
		vc_ctx[0].sin_th = sq_root[SQ_STEPS];
		vc_ctx[0].linear = sq_ctx[SQ_STEPS].linear || (sq_root[SQ_STEPS] == '0);
	end
	assign vc_x[0]   = cw_t'({{(CORDIC_W-ROOT_W){1'b0}}, sq_ctx[SQ_STEPS].big_d});
	assign vc_y[0]   = cw_t'({{(CORDIC_W-ROOT_W){1'b0}}, sq_root[SQ_STEPS]});
	assign vc_z[0]   = '0;
	assign vc_vld[0] = sq_vld[SQ_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vc
		vs_cordic_cell u_cell (
			.clk    (clk),
			.en     (adv),
			.rotate (1'b0),
			.idx    (5'(i)),
			.x_in   (vc_x[i]),
			.y_in   (vc_y[i]),
			.z_in   (vc_z[i]),
			.x_q    (vc_x[i+1]),
			.y_q    (vc_y[i+1]),
			.z_q    (vc_z[i+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vc_vld[i+1] <= 1'b0;
			end else if (adv) begin
				vc_vld[i+1] <= vc_vld[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				vc_ctx[i+1] <= vc_ctx[i];
			end
		end
	end

	// ---------------- angle stage: theta*(1-t) and theta*t
	logic                     v_s5;
	ctx_t                     ctx_s5;
	logic signed [PROD_W-1:0] pa_s5;
	logic signed [PROD_W-1:0] pb_s5;
	logic signed [15:0]       t_one_m;
	logic signed [15:0]       t_fwd;

	assign t_one_m = {1'b0, 15'(ONE) - vc_ctx[CORDIC_STEPS].t};
	assign t_fwd   = {1'b0, vc_ctx[CORDIC_STEPS].t};

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s5 <= vc_ctx[CORDIC_STEPS];
			pa_s5  <= vc_z[CORDIC_STEPS] * t_one_m;
			pb_s5  <= vc_z[CORDIC_STEPS] * t_fwd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= vc_vld[CORDIC_STEPS];
		end
	end

	// ---------------- rotation CORDIC chains: lane 0 sin((1-t)theta), lane 1 sin(t theta)
	cw_t  rc_x   [2][CORDIC_STEPS+1];
	cw_t  rc_y   [2][CORDIC_STEPS+1];
	cw_t  rc_z   [2][CORDIC_STEPS+1];
	ctx_t rc_ctx [CORDIC_STEPS+1];
	logic rc_vld [CORDIC_STEPS+1];
	logic signed [PROD_W-1:0] pa_rnd;
	logic signed [PROD_W-1:0] pb_rnd;

	// round half up back to Q30
	assign pa_rnd = pa_s5 + PROD_W'(ONE / 2);
	assign pb_rnd = pb_s5 + PROD_W'(ONE / 2);

	assign rc_z[0][0] = pa_rnd[CORDIC_W+FRAC_BITS-1:FRAC_BITS];
	assign rc_z[1][0] = pb_rnd[CORDIC_W+FRAC_BITS-1:FRAC_BITS];
	assign rc_ctx[0]  = ctx_s5;
	assign rc_vld[0]  = v_s5;

	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign rc_x[l][0] = cw_t'(INV_GAIN);
		assign rc_y[l][0] = '0;
		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rc
			vs_cordic_cell u_cell (
				.clk    (clk),
				.en     (adv),
				.rotate (1'b1),
				.idx    (5'(i)),
				.x_in   (rc_x[l][i]),
				.y_in   (rc_y[l][i]),
				.z_in   (rc_z[l][i]),
				.x_q    (rc_x[l][i+1]),
				.y_q    (rc_y[l][i+1]),
				.z_q    (rc_z[l][i+1])
			);
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rc_ctx
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rc_vld[i+1] <= 1'b0;
			end else if (adv) begin
				rc_vld[i+1] <= rc_vld[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rc_ctx[i+1] <= rc_ctx[i];
			end
		end
	end

	// ---------------- product stages: weighted sum, then magnitude plus half divisor
	logic                   v_s6;
	ctx_t                   ctx_s6;
	logic signed [WP_W-1:0] ws_s6 [3];
	logic signed [WP_W-1:0] we_s6 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s6 <= rc_ctx[CORDIC_STEPS];
			for (int k = 0; k < 3; k++) begin
				ws_s6[k] <= rc_ctx[CORDIC_STEPS].s[k] * rc_y[0][CORDIC_STEPS];
				we_s6[k] <= rc_ctx[CORDIC_STEPS].e[k] * rc_y[1][CORDIC_STEPS];
			end
		end
	end

	logic                    v_s7;
	ctx_t                    ctx_s7;
	logic [NUM_W-1:0]        m_s7 [3];
	logic [2:0]              neg_s7;
	logic signed [NUM_W-1:0] num [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k] = {ws_s6[k][WP_W-1], ws_s6[k]} + {we_s6[k][WP_W-1], we_s6[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s7 <= ctx_s6;
			for (int k = 0; k < 3; k++) begin
				neg_s7[k] <= num[k][NUM_W-1];
				m_s7[k]   <= (num[k][NUM_W-1] ? NUM_W'(-num[k]) : NUM_W'(num[k]))
					+ {{(NUM_W-ROOT_W){1'b0}}, ctx_s6.sin_th >> 1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s6 <= rc_vld[CORDIC_STEPS];
			v_s7 <= v_s6;
		end
	end

	// ---------------- divider chain: three lanes sharing the sin(theta) divisor
	logic [NUM_W-1:0] dv_rem [3][DIV_STEPS+1];
	logic [QUO_W-1:0] dv_quo [3][DIV_STEPS+1];
	ctx_t             dv_ctx [DIV_STEPS+1];
	logic [2:0]       dv_neg [DIV_STEPS+1];
	logic             dv_vld [DIV_STEPS+1];

	assign dv_ctx[0] = ctx_s7;
	assign dv_neg[0] = neg_s7;
	assign dv_vld[0] = v_s7;

	for (genvar l = 0; l < 3; l++) begin : g_dlane
		assign dv_rem[l][0] = m_s7[l];
		assign dv_quo[l][0] = '0;
		for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dv
			vs_div_cell u_cell (
				.clk    (clk),
				.en     (adv),
				.sh     (5'(DIV_STEPS - 1 - i)),
				.den    (dv_ctx[i].sin_th),
				.rem_in (dv_rem[l][i]),
				.quo_in (dv_quo[l][i]),
				.rem_q  (dv_rem[l][i+1]),
				.quo_q  (dv_quo[l][i+1])
			);
		end
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dv_ctx
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[i+1] <= 1'b0;
			end else if (adv) begin
				dv_vld[i+1] <= dv_vld[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctx[i+1] <= dv_ctx[i];
				dv_neg[i+1] <= dv_neg[i];
			end
		end
	end

	// ---------------- output register: pick the path, saturate, hold until taken
	// A quotient that fills all bits is at least 2^17 and saturates either way.
	comp_t             res [3];
	logic signed [20:0] slerp_val [3];
	comp_t             out_q [3];
	logic              linear_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			slerp_val[k] = dv_neg[DIV_STEPS][k]
				? -{3'b0, dv_quo[k][DIV_STEPS]} : {3'b0, dv_quo[k][DIV_STEPS]};
			res[k] = dv_ctx[DIV_STEPS].linear ? dv_ctx[DIV_STEPS].lin_res[k]
				: sat16(slerp_val[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_vld[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			linear_q <= dv_ctx[DIV_STEPS].linear;
			for (int k = 0; k < 3; k++) begin
				out_q[k] <= res[k];
			end
		end
	end

	assign out_x       = out_q[0];
	assign out_y       = out_q[1];
	assign out_z       = out_q[2];
	assign linear_path = linear_q;

	// ---------------- checks
	// A zero sine leaving the square root chain must force the linear blend.
	a_zero_sin_linear: assert property (@(posedge clk) disable iff (!arst_n)
		vc_vld[1] && (vc_ctx[1].sin_th == '0) |-> vc_ctx[1].linear)
		else $error("zero sin(theta) without linear blend");

	// The square root of a radicand at most 2^60 never exceeds 2^30.
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld[SQ_STEPS] |-> (sq_root[SQ_STEPS] <= ROOT_W'(1 << ANG_BITS)))
		else $error("square root out of range");

	// While the output beat is held, the chains must not move.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(sq_vld[1]) && $stable(vc_vld[1]) && $stable(dv_vld[DIV_STEPS]))
		else $error("pipeline moved during stall");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the vector slerp pipeline with a bit-exact predictor.
module tb_top;
	import vs_pkg::*;

	localparam int LATENCY    = 117;
	localparam int WATCHDOG   = 4000;
	localparam int N_RANDOM   = 1000;

	typedef struct {
		logic signed [15:0] sx, sy, sz, ex, ey, ez;
		logic [14:0]        t;
	} vec_pair_t;

	typedef struct {
		logic signed [15:0] x, y, z;
		logic               lin;
	} blend_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [THR_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	comp_t start_x = '0, start_y = '0, start_z = '0;
	comp_t end_x = '0, end_y = '0, end_z = '0;
	logic [14:0] blend = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	comp_t out_x, out_y, out_z;
	logic linear_path;

	vec_pair_t  pair_q[$];
	blend_out_t want_q[$];
	longint     thresh_model = THRESH_RESET;
	int         n_err = 0;
	int         idle_cnt = 0;
	bit         feed_hold = 1'b0;
	int         tx_gap = 0;
	int         rx_gap = 0;
	int         tx_draw = 0;
	int         rx_draw = 0;

	// Flags captured at the rising edge so the falling-edge driver knows what was taken.
	bit in_ready_seen = 1'b0;
	bit out_seen = 1'b0;

	vector_slerp_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z), .blend(blend),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .linear_path(linear_path)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------- predictor ----------------
	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rshift_away(longint v, int s);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 << (s - 1))) >>> s;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint div_away(longint num, longint den);
		longint m;
		m = num < 0 ? -num : num;
		m = (m + den / 2) / den;
		return num < 0 ? -m : m;
	endfunction

	function automatic longint angle_of(int i);
		case (i)
			0: return 843314857;
			1: return 497837829;
			2: return 263043837;
			3: return 133525159;
			4: return 67021687;
			5: return 33543516;
			6: return 16775851;
			7: return 8388437;
			8: return 4194283;
			9: return 2097149;
			default: return 64'sd1 << (ANG_BITS - i);
		endcase
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint vec_atan2(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += angle_of(i);
			end else begin
				x -= dx; y += dy; z -= angle_of(i);
			end
		end
		return z;
	endfunction

	function automatic longint rot_sin(longint z);
		longint x, y, dx, dy;
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= angle_of(i);
			end else begin
				x += dx; y -= dy; z += angle_of(i);
			end
		end
		return y;
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic blend_out_t slerp_predict(vec_pair_t p);
		longint s[3], e[3], r[3];
		longint t, dot2, d, dc, big_d, sin_th, theta, a0, a1, w0, w1;
		bit lin;
		blend_out_t o;
		s[0] = p.sx; s[1] = p.sy; s[2] = p.sz;
		e[0] = p.ex; e[1] = p.ey; e[2] = p.ez;
		t = p.t;
		if (t > ONE) t = ONE;
		lin = 1'b0;
		dot2 = s[0] * e[0] + s[1] * e[1] + s[2] * e[2];
		if (dot2 < 0) begin
			dot2 = -dot2;
			for (int k = 0; k < 3; k++) e[k] = -e[k];
		end
		d = (dot2 + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (d > thresh_model) begin
			lin = 1'b1;
		end else begin
			dc = d > ONE ? ONE : d;
			big_d = dc << (ANG_BITS - FRAC_BITS);
			sin_th = root_floor((64'd1 << 60) - longint'(big_d * big_d));
			if (sin_th == 0) begin
				lin = 1'b1;
			end else begin
				theta = vec_atan2(sin_th, big_d);
				a0 = (theta * (ONE - t) + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
				a1 = (theta * t + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
				w0 = rot_sin(a0);
				w1 = rot_sin(a1);
				for (int k = 0; k < 3; k++) r[k] = div_away(s[k] * w0 + e[k] * w1, sin_th);
			end
		end
		if (lin)
			for (int k = 0; k < 3; k++)
				r[k] = s[k] + rshift_away((e[k] - s[k]) * t, FRAC_BITS);
		o.x = clip16(r[0]);
		o.y = clip16(r[1]);
		o.z = clip16(r[2]);
		o.lin = lin;
		return o;
	endfunction

	// ---------------- stimulus ----------------
	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(0, 32768)) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [14:0] rand_blend();
		case ($urandom_range(0, 7))
			0: return 15'd0;
			1: return 15'd16384;
			2: return 15'($urandom);
			default: return 15'($urandom_range(0, 16384));
		endcase
	endfunction

	task automatic push_pair(input logic signed [15:0] sx, sy, sz, ex, ey, ez,
			input logic [14:0] t);
		vec_pair_t p;
		p.sx = sx; p.sy = sy; p.sz = sz; p.ex = ex; p.ey = ey; p.ez = ez; p.t = t;
		pair_q.push_back(p);
	endtask

	task automatic push_random(input int n);
		logic signed [15:0] sx, sy, sz;
		for (int i = 0; i < n; i++) begin
			sx = rand_comp(); sy = rand_comp(); sz = rand_comp();
			case ($urandom_range(0, 3))
				// near-parallel pair: end is start nudged slightly
				0: push_pair(sx, sy, sz, sx + 16'($urandom_range(0, 8)) - 4,
					sy + 16'($urandom_range(0, 8)) - 4, sz, rand_blend());
				// near-antiparallel pair exercises the sign fold
				1: push_pair(sx, sy, sz, -sx, -sy, -sz + 16'($urandom_range(0, 4)),
					rand_blend());
				default: push_pair(sx, sy, sz, rand_comp(), rand_comp(), rand_comp(),
					rand_blend());
			endcase
		end
	endtask

	// Drain everything in flight, then let the pipe settle before touching the register.
	task automatic wait_drained();
		while (pair_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_thresh(input logic [THR_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		thresh_model = v;
	endtask

	// Present the next pending pair on the input port.
	task automatic drive_next();
		vec_pair_t p;
		p = pair_q.pop_front();
		start_x <= p.sx; start_y <= p.sy; start_z <= p.sz;
		end_x <= p.ex; end_y <= p.ey; end_z <= p.ez; blend <= p.t;
		in_valid <= 1'b1;
	endtask

	// Driver: hold each beat until accepted, draw a random gap before the next, throttle out_ready.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready_seen) begin
				tx_draw = $urandom_range(0, 5);
				if (tx_draw == 0 && pair_q.size() != 0 && !feed_hold) begin
					drive_next();
				end else begin
					in_valid <= 1'b0;
					tx_gap <= (tx_draw > 0) ? tx_draw - 1 : 0;
				end
			end else if (!in_valid) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
				end else if (pair_q.size() != 0 && !feed_hold) begin
					drive_next();
				end
			end
			if (out_seen) begin
				rx_draw = $urandom_range(0, 5);
				rx_gap <= rx_draw;
				out_ready <= (rx_draw == 0);
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				out_ready <= (rx_gap == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on input beats, compare on output beats.
	always @(posedge clk) begin
		in_ready_seen <= 1'b0;
		out_seen <= 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				vec_pair_t p;
				p.sx = start_x; p.sy = start_y; p.sz = start_z;
				p.ex = end_x; p.ey = end_y; p.ez = end_z; p.t = blend;
				want_q.push_back(slerp_predict(p));
				in_ready_seen <= 1'b1;
			end
			if (out_valid && out_ready) begin
				out_seen <= 1'b1;
				if (want_q.size() == 0) begin
					$error("unexpected output beat x=%0d y=%0d z=%0d", out_x, out_y, out_z);
					n_err++;
				end else begin
					blend_out_t w;
					w = want_q.pop_front();
					if (out_x !== w.x) begin
						$error("out_x expected %0d got %0d", w.x, out_x); n_err++;
					end
					if (out_y !== w.y) begin
						$error("out_y expected %0d got %0d", w.y, out_y); n_err++;
					end
					if (out_z !== w.z) begin
						$error("out_z expected %0d got %0d", w.z, out_z); n_err++;
					end
					if (linear_path !== w.lin) begin
						$error("linear_path expected %0d got %0d", w.lin, linear_path);
						n_err++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
		end
	end

	// Watchdog: no beat for too long means the pipe is stuck.
	always @(posedge clk) begin
		if (idle_cnt >= WATCHDOG && (want_q.size() != 0 || in_valid)) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: extremes, zero vectors, parallel, antiparallel, blend clamp.
		push_pair(16'sd16384, 0, 0, 0, 16'sd16384, 0, 15'd8192);
		push_pair(16'sd16384, 0, 0, 16'sd16384, 0, 0, 15'd5000);
		push_pair(16'sd16384, 0, 0, -16'sd16384, 0, 0, 15'd8192);
		push_pair(0, 0, 0, 0, 0, 0, 15'd0);
		push_pair(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'd16384);
		push_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'd4096);
		push_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 15'h7FFF);
		push_pair(16'sh7FFF, 0, 16'sh8000, 16'sh8000, 16'sh7FFF, 0, 15'd16385);
		push_pair(16'sd11585, 16'sd11585, 0, 16'sd16384, 0, 0, 15'd0);
		push_pair(16'sd11585, 16'sd11585, 0, 16'sd16384, 0, 0, 15'd16384);
		push_pair(16'sd16384, 0, 0, 16'sd16380, 16'sd300, 0, 15'd8192);
		push_pair(16'sd9459, 16'sd9459, 16'sd9459, -16'sd9459, 16'sd9459, 16'sd9459, 15'd12000);
		wait_drained();

		// Threshold at zero: only pairs whose dot rounds to zero take the slerp path.
		write_thresh(15'd0);
		push_random(150);
		wait_drained();
		// Threshold at one and beyond: dot clamp and zero-sine fallback.
		write_thresh(15'd16384);
		push_pair(16'sd16384, 0, 0, 16'sd16384, 0, 0, 15'd3000);
		push_pair(16'sh7FFF, 16'sh7FFF, 0, 16'sh7FFF, 16'sh7FFF, 0, 15'd9000);
		push_random(150);
		wait_drained();
		write_thresh(15'h7FFF);
		push_random(150);
		wait_drained();
		write_thresh(15'($urandom_range(15000, 16384)));
		push_random(150);
		// Hold the feed until every outstanding beat is back.
		while (pair_q.size() != 0 || in_valid) @(posedge clk);
		feed_hold = 1'b1;
		while (want_q.size() != 0) @(posedge clk);
		feed_hold = 1'b0;
		wait_drained();
		write_thresh(THRESH_RESET);
		push_random(N_RANDOM - 600);
		wait_drained();

		if (n_err == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
